// File: hw/rtl/gpr_pkg.sv
// Shared types, codes and reset tables of the GPIO port register block.
package gpr_pkg;

    // Default build values
    localparam int DEF_NUM_PINS  = 16;
    localparam int DEF_PORT_KIND = 0;

    // Pin and register widths
    localparam int PORT_W  = 16;
    localparam int FIELD_W = 32;

    // Command queue depth between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Operation codes of an input beat
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_PIN   = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_DRIVE = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    // Decoded commands handed from front to back
    localparam logic [2:0] CMD_READ  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_PIN   = 3'd2;
    localparam logic [2:0] CMD_NOP   = 3'd3;
    localparam logic [2:0] CMD_BAD   = 3'd4;

    // Register word indexes (byte offset / 4)
    localparam logic [3:0] REG_MODE  = 4'd0;
    localparam logic [3:0] REG_OTYPE = 4'd1;
    localparam logic [3:0] REG_SPEED = 4'd2;
    localparam logic [3:0] REG_PULL  = 4'd3;
    localparam logic [3:0] REG_IDR   = 4'd4;
    localparam logic [3:0] REG_ODR   = 4'd5;
    localparam logic [3:0] REG_BSRR  = 4'd6;
    localparam logic [3:0] REG_LOCK  = 4'd7;
    localparam logic [3:0] REG_AFRL  = 4'd8;
    localparam logic [3:0] REG_AFRH  = 4'd9;

    localparam logic [7:0] OFFSET_MAX = 8'h24;

    typedef struct packed {
        logic [2:0]         code;
        logic [3:0]         reg_idx;
        logic [FIELD_W-1:0] data;
        logic [3:0]         pin;
        logic               level;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    function automatic logic [FIELD_W-1:0] mode_reset(input int kind);
        logic [FIELD_W-1:0] v;
        unique case (kind)
            0:       v = 32'hA800_0000;
            1:       v = 32'h0000_0280;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [FIELD_W-1:0] pull_reset(input int kind);
        logic [FIELD_W-1:0] v;
        unique case (kind)
            0:       v = 32'h6400_0000;
            1:       v = 32'h0000_0100;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [FIELD_W-1:0] speed_reset(input int kind);
        logic [FIELD_W-1:0] v;
        unique case (kind)
            1:       v = 32'h0000_00C0;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/gpr_front.sv
// Front end: decode input beats into commands for the queue.
module gpr_front #(
    parameter int NUM_PINS = gpr_pkg::DEF_NUM_PINS
) (
    input  logic [1:0]   i_op,
    input  logic [7:0]   i_offset,
    input  logic [31:0]  i_write_data,
    input  logic [3:0]   i_in_pin,
    input  logic         i_in_level,
    output gpr_pkg::t_cmd o_cmd
);
    import gpr_pkg::*;

    logic w_off_ok;
    logic w_pin_ok;

    assign w_off_ok = (i_offset[1:0] == 2'b00) && (i_offset <= OFFSET_MAX);
    assign w_pin_ok = ({1'b0, i_in_pin} < 5'(NUM_PINS));

    always_comb begin
        o_cmd.reg_idx = i_offset[5:2];
        o_cmd.data    = i_write_data;
        o_cmd.pin     = i_in_pin;
        o_cmd.level   = i_in_level;
        unique case (i_op)
            OP_READ:  o_cmd.code = w_off_ok ? CMD_READ : CMD_BAD;
            OP_WRITE: o_cmd.code = w_off_ok ? CMD_WRITE : CMD_BAD;
            OP_PIN:   o_cmd.code = w_pin_ok ? CMD_PIN : CMD_NOP;
            default:  o_cmd.code = CMD_NOP;
        endcase
    end

endmodule

// File: hw/rtl/gpr_queue.sv
// Short command queue between the front and back ends.
module gpr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gpr_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output gpr_pkg::t_cmd  o_cmd,
    output gpr_pkg::t_qstat o_stat
);
    import gpr_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count,  n_count;

    function automatic logic [Q_PTR_W-1:0] next_ptr(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? next_ptr(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? next_ptr(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));

endmodule

// File: hw/rtl/gpr_back.sv
// Back end: register file, command execution and result register.
module gpr_back #(
    parameter int NUM_PINS  = gpr_pkg::DEF_NUM_PINS,
    parameter int PORT_KIND = gpr_pkg::DEF_PORT_KIND
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gpr_pkg::t_cmd   i_cmd,
    input  gpr_pkg::t_qstat i_qstat,
    output logic            o_pop,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic [1:0]      o_kind,
    output logic [31:0]     o_read_data,
    output logic [3:0]      o_drive_pin,
    output logic            o_drive_level,
    output logic            o_last
);
    import gpr_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRIVE = 1'b1;

    // Port registers
    logic [FIELD_W-1:0] r_mode,  n_mode;
    logic [PORT_W-1:0]  r_otype, n_otype;
    logic [FIELD_W-1:0] r_speed, n_speed;
    logic [FIELD_W-1:0] r_pull,  n_pull;
    logic [PORT_W-1:0]  r_idr,   n_idr;
    logic [PORT_W-1:0]  r_odr,   n_odr;
    logic [PORT_W-1:0]  r_drv,   n_drv;
    logic [FIELD_W-1:0] r_afrl,  n_afrl;
    logic [FIELD_W-1:0] r_afrh,  n_afrh;

    // Sequencer
    logic              r_state, n_state;
    logic [PORT_W-1:0] r_pend,  n_pend;

    // Result register
    logic        r_ov;
    logic [1:0]  r_kind;
    logic [31:0] r_data;
    logic [3:0]  r_pin;
    logic        r_lvl;
    logic        r_last;

    logic        w_slot_free;
    logic        e_emit;
    logic [1:0]  e_kind;
    logic [31:0] e_data;
    logic [3:0]  e_pin;
    logic        e_lvl;
    logic        e_last;

    logic [PORT_W-1:0]  w_new_odr;
    logic [PORT_W-1:0]  w_changed;
    logic [FIELD_W-1:0] w_read;
    logic [1:0]         w_pin_pull;
    logic [1:0]         w_pin_mode;
    logic [3:0]         w_low_pin;

    function automatic logic [PORT_W-1:0] pin_mask();
        logic [PORT_W-1:0] m;
        for (int i = 0; i < PORT_W; i++) begin
            m[i] = (i < NUM_PINS);
        end
        return m;
    endfunction

    function automatic logic [PORT_W-1:0] active_mask(input logic [FIELD_W-1:0] mode);
        logic [PORT_W-1:0] m;
        for (int i = 0; i < PORT_W; i++) begin
            m[i] = |mode[2*i +: 2];
        end
        return m;
    endfunction

    function automatic logic [3:0] lowest_pin(input logic [PORT_W-1:0] v);
        logic [3:0] p;
        p = '0;
        for (int i = PORT_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                p = 4'(i);
            end
        end
        return p;
    endfunction

    assign w_slot_free = !r_ov || !i_out_stall;
    assign w_pin_pull  = 2'(r_pull >> {i_cmd.pin, 1'b0});
    assign w_pin_mode  = 2'(r_mode >> {i_cmd.pin, 1'b0});
    assign w_low_pin   = lowest_pin(r_pend);

    always_comb begin
        case (i_cmd.reg_idx)
            REG_MODE:  w_read = r_mode;
            REG_OTYPE: w_read = {16'h0, r_otype};
            REG_SPEED: w_read = r_speed;
            REG_PULL:  w_read = r_pull;
            REG_IDR:   w_read = {16'h0, r_idr};
            REG_ODR:   w_read = {16'h0, r_odr};
            REG_AFRL:  w_read = r_afrl;
            REG_AFRH:  w_read = r_afrh;
            default:   w_read = '0;
        endcase
    end

    always_comb begin
        if (i_cmd.reg_idx == REG_BSRR) begin
            w_new_odr = (r_odr & ~i_cmd.data[31:16]) | i_cmd.data[15:0];
        end else begin
            w_new_odr = i_cmd.data[15:0];
        end
        w_changed = (r_drv ^ w_new_odr) & active_mask(r_mode) & pin_mask();
    end

    always_comb begin
        n_mode  = r_mode;
        n_otype = r_otype;
        n_speed = r_speed;
        n_pull  = r_pull;
        n_idr   = r_idr;
        n_odr   = r_odr;
        n_drv   = r_drv;
        n_afrl  = r_afrl;
        n_afrh  = r_afrh;
        n_state = r_state;
        n_pend  = r_pend;
        o_pop   = 1'b0;
        e_emit  = 1'b0;
        e_kind  = KIND_DONE;
        e_data  = '0;
        e_pin   = '0;
        e_lvl   = 1'b0;
        e_last  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_qstat.empty && w_slot_free) begin
                    o_pop  = 1'b1;
                    e_emit = 1'b1;
                    case (i_cmd.code)
                        CMD_READ: begin
                            e_kind = KIND_READ;
                            e_data = w_read;
                        end
                        CMD_BAD: begin
                            e_kind = KIND_BAD;
                        end
                        CMD_PIN: begin
                            if (w_pin_pull != 2'b00 && w_pin_mode == 2'b00) begin
                                n_idr[i_cmd.pin] = i_cmd.level;
                            end
                        end
                        CMD_WRITE: begin
                            case (i_cmd.reg_idx) inside
                                REG_MODE:  n_mode  = i_cmd.data;
                                REG_OTYPE: n_otype = i_cmd.data[15:0];
                                REG_SPEED: n_speed = i_cmd.data;
                                REG_PULL:  n_pull  = i_cmd.data;
                                REG_AFRL:  n_afrl  = i_cmd.data;
                                REG_AFRH:  n_afrh  = i_cmd.data;
                                REG_ODR, REG_BSRR: begin
                                    n_odr = w_new_odr;
                                    n_drv = w_new_odr;
                                    // hold the done beat until the drive events drain
                                    if (w_changed != '0) begin
                                        n_pend  = w_changed;
                                        n_state = ST_DRIVE;
                                        e_emit  = 1'b0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            ST_DRIVE: begin
                if (w_slot_free) begin
                    e_emit = 1'b1;
                    if (r_pend != '0) begin
                        e_kind = KIND_DRIVE;
                        e_pin  = w_low_pin;
                        e_lvl  = r_odr[w_low_pin];
                        e_last = 1'b0;
                        n_pend[w_low_pin] = 1'b0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= mode_reset(PORT_KIND);
            r_otype <= '0;
            r_speed <= speed_reset(PORT_KIND);
            r_pull  <= pull_reset(PORT_KIND);
            r_idr   <= '0;
            r_odr   <= '0;
            r_drv   <= '0;
            r_afrl  <= '0;
            r_afrh  <= '0;
            r_state <= ST_IDLE;
            r_pend  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_otype <= n_otype;
            r_speed <= n_speed;
            r_pull  <= n_pull;
            r_idr   <= n_idr;
            r_odr   <= n_odr;
            r_drv   <= n_drv;
            r_afrl  <= n_afrl;
            r_afrh  <= n_afrh;
            r_state <= n_state;
            r_pend  <= n_pend;
            if (w_slot_free) begin
                r_ov <= e_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free && e_emit) begin
            r_kind <= e_kind;
            r_data <= e_data;
            r_pin  <= e_pin;
            r_lvl  <= e_lvl;
            r_last <= e_last;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_kind        = r_kind;
    assign o_read_data   = r_data;
    assign o_drive_pin   = r_pin;
    assign o_drive_level = r_lvl;
    assign o_last        = r_last;

endmodule

// File: hw/rtl/gpio_port_registers.sv
// Top level of the GPIO port register block: front decode, queue, back end.
//
// A 16-pin GPIO port behind a ten-word register map (mode, output type,
// speed, pull, input data, output data, bit set/reset, lock, alternate
// function low and high). Each input beat is a bus read, a bus write or a
// level change seen on an external pin; each result beat carries a kind
// (read data, access done, pin drive event, bad offset) and a last flag on
// the final beat of its item. The front decodes a beat into a command in
// the same cycle and pushes it into a two-entry queue, so the input side
// keeps taking beats while the back end works or the output is stalled,
// until the queue is full. While the output is not stalled, the back end
// pops one command per cycle into a result register; a read, a pin event,
// a bad offset or a plain write yields one result beat. A write to output
// data or bit set/reset that changes N driven pins with nonzero mode holds
// the back end after its pop for one drive event per cycle in ascending
// pin order, then the done beat. Items with no drive events thus sustain
// one per cycle; the drive-event sequencer sets the rate of output writes.
module gpio_port_registers #(
    parameter int NUM_PINS  = gpr_pkg::DEF_NUM_PINS,
    parameter int PORT_KIND = gpr_pkg::DEF_PORT_KIND
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_offset,
    input  logic [31:0] i_write_data,
    input  logic [3:0]  i_in_pin,
    input  logic        i_in_level,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_read_data,
    output logic [3:0]  o_drive_pin,
    output logic        o_drive_level,
    output logic        o_last
);
    import gpr_pkg::*;

    t_cmd   w_front_cmd;
    t_cmd   w_head_cmd;
    t_qstat w_qstat;
    logic   w_push;
    logic   w_pop;

    // Stall the input only while the queue is full.
    assign o_in_stall = w_qstat.full;
    assign w_push     = i_in_valid && !w_qstat.full;

    gpr_front #(
        .NUM_PINS (NUM_PINS)
    ) u_front (
        .i_op         (i_op),
        .i_offset     (i_offset),
        .i_write_data (i_write_data),
        .i_in_pin     (i_in_pin),
        .i_in_level   (i_in_level),
        .o_cmd        (w_front_cmd)
    );

    gpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_stat  (w_qstat)
    );

    gpr_back #(
        .NUM_PINS  (NUM_PINS),
        .PORT_KIND (PORT_KIND)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_head_cmd),
        .i_qstat       (w_qstat),
        .o_pop         (w_pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_read_data   (o_read_data),
        .o_drive_pin   (o_drive_pin),
        .o_drive_level (o_drive_level),
        .o_last        (o_last)
    );

    // Drive events never close an item; every other kind does.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_kind == KIND_DRIVE) != o_last))
        else $error("last flag does not match result kind");

    // Only read results carry data.
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != KIND_READ) |-> (o_read_data == '0))
        else $error("nonzero data on a non-read result");

    // The back end never pops an empty queue.
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("pop from empty command queue");

    // The queue comes out of reset empty, so input is open.
    a_reset_open: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_in_stall && w_qstat.empty))
        else $error("queue not empty after reset");

endmodule

// File: dv/gpio_port_registers_tb.sv
// Self-checking testbench of the GPIO port register block.
`timescale 1ns / 100ps

module gpio_port_registers_tb;
    import gpr_pkg::*;

    // Build of the block under test, mirrored by the predictor below
    localparam int PIN_COUNT = 16;
    localparam int PORT_SEL  = 0;

    // Op code 3 is unused by the block: it must answer with a plain done beat
    localparam logic [1:0] OP_SPARE = 2'd3;

    // One result beat as the block presents it
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] data;
        logic [3:0]  pin;
        logic        level;
        logic        last;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op = '0;
    logic [7:0]  i_offset = '0;
    logic [31:0] i_write_data = '0;
    logic [3:0]  i_in_pin = '0;
    logic        i_in_level = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [31:0] o_read_data;
    logic [3:0]  o_drive_pin;
    logic        o_drive_level;
    logic        o_last;

    gpio_port_registers #(
        .NUM_PINS (PIN_COUNT),
        .PORT_KIND(PORT_SEL)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_offset     (i_offset),
        .i_write_data (i_write_data),
        .i_in_pin     (i_in_pin),
        .i_in_level   (i_in_level),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_read_data  (o_read_data),
        .o_drive_pin  (o_drive_pin),
        .o_drive_level(o_drive_level),
        .o_last       (o_last)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the port registers and the beats still owed by the block
    // ------------------------------------------------------------------
    logic [31:0] sh_mode, sh_speed, sh_pull, sh_afrl, sh_afrh;
    logic [15:0] sh_otype, sh_idr, sh_odr, sh_driven;

    t_beat pending_beats[$];
    t_beat head_beat;

    int  err_count = 0;
    bit  calm = 1'b0;        // set for the closing stretch: no gaps, no stalls
    int  stall_left = 0;
    int  n_reads = 0, n_writes = 0, n_pins = 0, n_spare = 0;
    int  n_drive = 0, n_bad = 0;

    function automatic logic [7:0] reg_offset(input logic [3:0] idx);
        return {2'b00, idx, 2'b00};
    endfunction

    task automatic reset_shadow();
        case (PORT_SEL)
            0: begin
                sh_mode = 32'hA800_0000; sh_pull = 32'h6400_0000; sh_speed = '0;
            end
            1: begin
                sh_mode = 32'h0000_0280; sh_pull = 32'h0000_0100; sh_speed = 32'h0000_00C0;
            end
            default: begin
                sh_mode = '0; sh_pull = '0; sh_speed = '0;
            end
        endcase
        sh_otype  = '0;
        sh_idr    = '0;
        sh_odr    = '0;
        sh_driven = '0;
        sh_afrl   = '0;
        sh_afrh   = '0;
    endtask

    task automatic owe_beat(input logic [1:0] kind, input logic [31:0] data,
                            input logic [3:0] pin, input logic level, input logic last);
        t_beat b;
        b.kind  = kind;
        b.data  = data;
        b.pin   = pin;
        b.level = level;
        b.last  = last;
        pending_beats.push_back(b);
    endtask

    // Owe one drive event per changed pin with nonzero mode, lowest pin first
    task automatic owe_pin_drives();
        logic [15:0] changed;
        changed   = sh_driven ^ sh_odr;
        sh_driven = sh_odr;
        for (int i = 0; i < 16; i++) begin
            if (i < PIN_COUNT && changed[i] && sh_mode[2*i +: 2] != 2'b00)
                owe_beat(KIND_DRIVE, '0, 4'(i), sh_odr[i], 1'b0);
        end
    endtask

    // Advance the shadow registers by one accepted beat and owe its results
    task automatic predict_port_access(input logic [1:0] op, input logic [7:0] off,
                                       input logic [31:0] wd, input logic [3:0] pin,
                                       input logic lvl);
        logic [3:0]  idx;
        logic [31:0] rd;
        logic        ok;
        idx = off[5:2];
        ok  = (off[1:0] == 2'b00) && (off <= OFFSET_MAX);
        rd  = '0;
        case (op)
            OP_READ: begin
                if (!ok) begin
                    owe_beat(KIND_BAD, '0, '0, 1'b0, 1'b1);
                end else begin
                    case (idx)
                        REG_MODE:  rd = sh_mode;
                        REG_OTYPE: rd = {16'h0, sh_otype};
                        REG_SPEED: rd = sh_speed;
                        REG_PULL:  rd = sh_pull;
                        REG_IDR:   rd = {16'h0, sh_idr};
                        REG_ODR:   rd = {16'h0, sh_odr};
                        REG_AFRL:  rd = sh_afrl;
                        REG_AFRH:  rd = sh_afrh;
                        default:   rd = '0;
                    endcase
                    owe_beat(KIND_READ, rd, '0, 1'b0, 1'b1);
                end
            end
            OP_WRITE: begin
                if (!ok) begin
                    owe_beat(KIND_BAD, '0, '0, 1'b0, 1'b1);
                end else begin
                    case (idx)
                        REG_MODE:  sh_mode  = wd;
                        REG_OTYPE: sh_otype = wd[15:0];
                        REG_SPEED: sh_speed = wd;
                        REG_PULL:  sh_pull  = wd;
                        REG_ODR: begin
                            sh_odr = wd[15:0];
                            owe_pin_drives();
                        end
                        REG_BSRR: begin
                            // set bits win over clear bits on the same pin
                            sh_odr = (sh_odr & ~wd[31:16]) | wd[15:0];
                            owe_pin_drives();
                        end
                        REG_AFRL:  sh_afrl = wd;
                        REG_AFRH:  sh_afrh = wd;
                        default:   ;
                    endcase
                    owe_beat(KIND_DONE, '0, '0, 1'b0, 1'b1);
                end
            end
            OP_PIN: begin
                // latch the level only on a pulled pin that is in input mode
                if (pin < PIN_COUNT && sh_pull[2*pin +: 2] != 2'b00
                        && sh_mode[2*pin +: 2] == 2'b00)
                    sh_idr[pin] = lvl;
                owe_beat(KIND_DONE, '0, '0, 1'b0, 1'b1);
            end
            default: owe_beat(KIND_DONE, '0, '0, 1'b0, 1'b1);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input side: one beat per call, held until the block takes it
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [1:0] op, input logic [7:0] off,
                             input logic [31:0] wd, input logic [3:0] pin,
                             input logic lvl);
        // drop valid for a random burst now and then
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_offset     <= off;
        i_write_data <= wd;
        i_in_pin     <= pin;
        i_in_level   <= lvl;
        do @(posedge i_clk); while (o_in_stall);
        predict_port_access(op, off, wd, pin, lvl);
        case (op)
            OP_READ:  n_reads++;
            OP_WRITE: n_writes++;
            OP_PIN:   n_pins++;
            default:  n_spare++;
        endcase
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] wd);
        send_beat(OP_WRITE, reg_offset(idx), wd, 4'($urandom), 1'($urandom));
    endtask

    task automatic read_reg(input logic [3:0] idx);
        send_beat(OP_READ, reg_offset(idx), $urandom, 4'($urandom), 1'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall bursts, then check every accepted beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (calm) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 16);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_beats.size() == 0) begin
                $error("result beat with nothing owed: kind %0d data 0x%0h pin %0d",
                       o_kind, o_read_data, o_drive_pin);
                err_count++;
            end else begin
                head_beat = pending_beats.pop_front();
                check_field("kind", 32'(head_beat.kind), 32'(o_kind));
                check_field("read_data", head_beat.data, o_read_data);
                check_field("drive_pin", 32'(head_beat.pin), 32'(o_drive_pin));
                check_field("drive_level", 32'(head_beat.level), 32'(o_drive_level));
                check_field("last", 32'(head_beat.last), 32'(o_last));
                if (head_beat.kind == KIND_DRIVE) n_drive++;
                if (head_beat.kind == KIND_BAD)   n_bad++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Read back the per-kind mode and pull reset values and the lock word
    task automatic test_reset_values();
        read_reg(REG_MODE);
        read_reg(REG_PULL);
        read_reg(REG_LOCK);
    endtask

    // Misaligned and out-of-map offsets on both reads and writes
    task automatic test_bad_offsets();
        send_beat(OP_READ, 8'h01, 32'hFFFF_FFFF, 4'hF, 1'b1);
        send_beat(OP_WRITE, 8'hFF, 32'hFFFF_FFFF, 4'h0, 1'b0);
        send_beat(OP_READ, 8'h28, 32'h0, 4'h0, 1'b0);
    endtask

    // Output data and bit set/reset: full-port swings, set-over-clear, masks
    task automatic test_output_drive();
        write_reg(REG_MODE, 32'hFFFF_FFFF);
        write_reg(REG_ODR, 32'hFFFF_FFFF);     // all sixteen pins rise
        write_reg(REG_BSRR, 32'hFFFF_0000);    // all sixteen pins fall
        write_reg(REG_BSRR, 32'h0001_0001);    // set and clear on pin 0: set wins
        write_reg(REG_BSRR, 32'h0000_0000);    // no change, no drive events
        write_reg(REG_MODE, 32'h5555_0000);    // low byte of pins back to input
        write_reg(REG_ODR, 32'h0000_F0F0);     // only the upper pins drive
    endtask

    // Pin level events gated by pull and mode, read-only input data
    task automatic test_pin_events();
        write_reg(REG_MODE, 32'h0000_0000);
        write_reg(REG_PULL, 32'hAAAA_AAAA);
        send_beat(OP_PIN, 8'hFF, 32'hFFFF_FFFF, 4'd15, 1'b1);
        send_beat(OP_PIN, 8'h00, 32'h0, 4'd0, 1'b1);
        send_beat(OP_PIN, 8'h00, 32'h0, 4'd0, 1'b0);
        write_reg(REG_IDR, 32'hFFFF_FFFF);     // ignored
        read_reg(REG_IDR);
    endtask

    // Narrow output type, alternate functions, lock writes, unused op code
    task automatic test_misc_registers();
        write_reg(REG_OTYPE, 32'hFFFF_FFFF);
        read_reg(REG_OTYPE);
        write_reg(REG_AFRH, 32'h8000_0001);
        read_reg(REG_AFRH);
        write_reg(REG_LOCK, 32'hFFFF_FFFF);
        send_beat(OP_SPARE, 8'h14, 32'hFFFF_FFFF, 4'hF, 1'b1);
    endtask

    // Mostly well-formed register traffic with random content, plus noise
    task automatic test_random_traffic(input int count);
        int          pick;
        logic [3:0]  idx;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                // output updates; bias some toward masked set/reset patterns
                idx = ($urandom_range(0, 1) == 0) ? REG_ODR : REG_BSRR;
                write_reg(idx, ($urandom_range(0, 3) == 0) ? ($urandom & $urandom) : $urandom);
            end else if (pick < 45) begin
                // reshape modes and pulls; sparse modes let pin events through
                case ($urandom_range(0, 3))
                    0: write_reg(REG_MODE, $urandom & $urandom);
                    1: write_reg(REG_MODE, ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                                        : $urandom);
                    default: write_reg(REG_PULL, $urandom);
                endcase
            end else if (pick < 65) begin
                send_beat(OP_PIN, 8'($urandom), $urandom, 4'($urandom), 1'($urandom));
            end else if (pick < 85) begin
                read_reg(4'($urandom_range(0, 9)));
            end else if (pick < 93) begin
                write_reg(4'($urandom_range(0, 9)), $urandom);
            end else if (pick < 98) begin
                send_beat(2'($urandom_range(0, 1)), 8'($urandom), $urandom,
                          4'($urandom), 1'($urandom));
            end else begin
                send_beat(OP_SPARE, 8'($urandom), $urandom, 4'($urandom), 1'($urandom));
            end
        end
    endtask

    // Hold the input side until the block owes nothing, then resume
    task automatic test_drain_pause();
        i_in_valid <= 1'b0;
        wait (pending_beats.size() == 0);
        @(posedge i_clk);
        read_reg(REG_ODR);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_shadow();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_bad_offsets();
        test_output_drive();
        test_pin_events();
        test_misc_registers();
        test_random_traffic(130);
        test_drain_pause();
        calm = 1'b1;               // closing stretch runs at full rate
        test_random_traffic(54);

        i_in_valid <= 1'b0;
        wait (pending_beats.size() == 0);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d reads, %0d writes, %0d pin events, %0d unused-op beats;",
                 n_reads, n_writes, n_pins, n_spare);
        $display("checked %0d drive events and %0d bad-offset answers.", n_drive, n_bad);
        if (err_count == 0 && pending_beats.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
